@@ rtl/fir_pkg.sv @@
// FIR filter package: default sizes, width helpers, request codes and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps

package fir_pkg;

  localparam int DEF_TAPS        = 25;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COEF_BITS   = 16;

  // request mode codes
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // bits needed to address one coefficient slot
  function automatic int idx_width(input int taps);
    idx_width = (taps > 1) ? $clog2(taps) : 1;
  endfunction

  // width of the sum of taps products, with one spare bit
  function automatic int acc_width(input int taps, input int sbits, input int cbits);
    acc_width = sbits + cbits + ((taps > 1) ? $clog2(taps) : 0) + 1;
  endfunction

  typedef struct packed {
    logic coef_wr;   // write one coefficient slot
    logic shift_in;  // push new sample into the history ring
    logic step;      // one MAC step: coef read, ring rotate
    logic acc_clr;   // clear accumulator
    logic round;     // register the rounded sum
    logic load_out;  // saturate and load the output register
  } fir_cmd_t;

endpackage

@@ rtl/fir_if.sv @@
// Valid/ready channel interfaces for the FIR filter input and result streams.
// Depends on nothing.
`timescale 1ns / 1ps

interface fir_in_if #(
  parameter int IDX_BITS    = 5,
  parameter int COEF_BITS   = 16,
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [IDX_BITS-1:0]           coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, mode, coef_index, coef_value, sample_in, input ready);
  modport sink   (input valid, mode, coef_index, coef_value, sample_in, output ready);
  modport mon    (input valid, ready, mode, coef_index, coef_value, sample_in);
endinterface

interface fir_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
  modport mon    (input valid, ready, sample_out, clipped);
endinterface

@@ rtl/fir_ctrl.sv @@
// FIR sequencer: accepts requests, steps the shared MAC over all taps,
// then rounds and hands the result to the output register. Uses fir_pkg.
`timescale 1ns / 1ps

module fir_ctrl
  import fir_pkg::*;
#(
  parameter int TAPS  = DEF_TAPS,
  parameter int IDX_W = idx_width(DEF_TAPS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             mac_busy,
  output fir_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_ROUND,
    S_FINISH
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             in_acc;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign rd_addr   = cnt_r;

  always_comb begin
    cmd          = '0;
    cmd.coef_wr  = in_acc && (in_mode == MODE_COEF);
    cmd.shift_in = in_acc && (in_mode == MODE_SAMPLE);
    cmd.acc_clr  = in_acc && (in_mode == MODE_SAMPLE);
    cmd.step     = (state_r == S_RUN);
    cmd.round    = (state_r == S_ROUND);
    cmd.load_out = (state_r == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces one taken in the same cycle
      if ((state_r == S_FINISH) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_mode == MODE_SAMPLE)) begin
            cnt_r   <= IDX_W'(TAPS - 1);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          // slots are walked from the top down
          if (cnt_r == '0) state_r <= S_DRAIN;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_DRAIN: begin
          if (!mac_busy) state_r <= S_ROUND;
        end
        S_ROUND: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/fir_datapath.sv @@
// FIR datapath: coefficient memory with valid bits, rotating sample ring,
// pipelined multiply-accumulate, rounding and saturation. Uses fir_pkg.
`timescale 1ns / 1ps

module fir_datapath
  import fir_pkg::*;
#(
  parameter int TAPS        = DEF_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = DEF_COEF_BITS,
  parameter int IDX_W       = idx_width(DEF_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fir_cmd_t                      cmd,
  input  logic [IDX_W-1:0]              rd_addr,
  input  logic [IDX_W-1:0]              coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          mac_busy,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = acc_width(TAPS, SAMPLE_BITS, COEF_BITS);
  localparam int RSH    = COEF_BITS - 1;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (RSH - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

  // coefficient store; a slot never written since reset reads as zero
  logic [COEF_BITS-1:0]          coef_mem [TAPS];
  logic [TAPS-1:0]               coef_vld_r;
  logic [COEF_BITS-1:0]          coef_rd_r;
  logic                          coef_ok_r;
  logic                          idx_ok;

  // sample ring, newest at slot 0; rotates once per MAC step
  logic signed [SAMPLE_BITS-1:0] ring_r [TAPS];
  logic signed [SAMPLE_BITS-1:0] x_tap_r;
  logic                          s1_v_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          s2_v_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       rnd_sum;
  logic signed [ACC_W-1:0]       rnd_r;
  logic signed [COEF_BITS-1:0]   coef_s;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic                          clipped_r;

  assign idx_ok     = ({1'b0, coef_index} < (IDX_W + 1)'(TAPS));
  assign mac_busy   = s1_v_r || s2_v_r;
  assign coef_s     = coef_ok_r ? signed'(coef_rd_r) : '0;
  assign rnd_sum    = acc_r + HALF;
  assign sample_out = sample_out_r;
  assign clipped    = clipped_r;

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && idx_ok) coef_mem[coef_index] <= coef_value;
    if (cmd.step) coef_rd_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      coef_ok_r  <= 1'b0;
    end else begin
      if (cmd.coef_wr && idx_ok) coef_vld_r[coef_index] <= 1'b1;
      if (cmd.step) coef_ok_r <= coef_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) ring_r[i] <= '0;
    end else if (cmd.shift_in) begin
      ring_r[0] <= sample_in;
      for (int i = 1; i < TAPS; i++) ring_r[i] <= ring_r[i-1];
    end else if (cmd.step) begin
      ring_r[TAPS-1] <= ring_r[0];
      for (int i = 0; i < TAPS - 1; i++) ring_r[i] <= ring_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.step;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) x_tap_r <= ring_r[0];
    if (s1_v_r) prod_r <= PROD_W'(coef_s) * PROD_W'(x_tap_r);
    if (cmd.acc_clr) acc_r <= '0;
    else if (s2_v_r) acc_r <= acc_r + ACC_W'(prod_r);
    // round half up: add half an output LSB, then floor
    if (cmd.round) rnd_r <= rnd_sum >>> RSH;
    if (cmd.load_out) begin
      if (rnd_r > OUT_MAX) begin
        sample_out_r <= OUT_MAX[SAMPLE_BITS-1:0];
        clipped_r    <= 1'b1;
      end else if (rnd_r < OUT_MIN) begin
        sample_out_r <= OUT_MIN[SAMPLE_BITS-1:0];
        clipped_r    <= 1'b1;
      end else begin
        sample_out_r <= rnd_r[SAMPLE_BITS-1:0];
        clipped_r    <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/fir_filter_25_tap.sv @@
// FIR filter top level: joins the sequencer and the datapath to the
// request and result channels. Uses fir_pkg, fir_if, fir_ctrl, fir_datapath.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid / ready  mode, coef_index, coef_value, sample_in
//   out_ch   out  valid / ready  sample_out, clipped
//
// A coefficient request writes its slot on acceptance; an index of TAPS or
// more is ignored. A sample request's result passes through one MAC step per
// tap on the single shared multiplier, a pipeline drain, rounding and the
// load of the output register. Requests are taken only while the sequencer
// is idle, so a new sample waits until the last one's result is loaded.
// Reset invalidates all coefficients and clears the sample history.
// A finished result waits in the output register; the next request is taken
// meanwhile, and a second result waits only for that register to empty.
`timescale 1ns / 1ps

module fir_filter_25_tap
  import fir_pkg::*;
#(
  parameter int TAPS        = DEF_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = DEF_COEF_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  fir_in_if.sink    in_ch,
  fir_out_if.source out_ch
);

  localparam int IDX_W = idx_width(TAPS);

  fir_cmd_t         cmd;
  logic [IDX_W-1:0] rd_addr;
  logic             mac_busy;

  fir_ctrl #(
    .TAPS  (TAPS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .mac_busy  (mac_busy),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  fir_datapath #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .coef_index (in_ch.coef_index),
    .coef_value (in_ch.coef_value),
    .sample_in  (in_ch.sample_in),
    .mac_busy   (mac_busy),
    .sample_out (out_ch.sample_out),
    .clipped    (out_ch.clipped)
  );

endmodule

@@ rtl/fir_checker.sv @@
// Port-level checks for fir_filter_25_tap, bound to the top level.
// Uses fir_pkg.
`timescale 1ns / 1ps

module fir_checker
  import fir_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_mode,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample_out,
  input logic                   out_clipped
);

  logic       smp_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign smp_acc = in_valid && in_ready && (in_mode == MODE_SAMPLE);
  assign out_acc = out_valid && out_ready;

  // sample requests still owed a result
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_r + {1'b0, smp_acc} - {1'b0, out_acc};
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_out) && $stable(out_clipped))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result without a sample request");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    smp_acc |=> !in_ready)
    else $error("request taken while a sample is in progress");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_sample_out == {1'b0, {(SAMPLE_BITS - 1){1'b1}}}) ||
      (out_sample_out == {1'b1, {(SAMPLE_BITS - 1){1'b0}}}))
    else $error("clipped result is not a full-scale code");

endmodule

bind fir_filter_25_tap fir_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fir_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_mode        (in_ch.mode),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sample_out (out_ch.sample_out),
  .out_clipped    (out_ch.clipped)
);
